// ===== hw/rtl/sensor_frame_crc_check_decode_unit_assert.svh =====
// assertion macros for the sensor frame decoder
`ifndef SENSOR_FRAME_CRC_CHECK_DECODE_UNIT_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECK_DECODE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define SFCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sfcd assertion failed");

`define SFCD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sfcd assertion failed");

`else

`define SFCD_ASSERT(lbl, prop)

`define SFCD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== hw/rtl/sfcd_pkg.sv =====
package sfcd_pkg;

  localparam logic [3:0]  CRC_SPAN_BYTES = 4'd6;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  localparam logic [2:0] POS_FIRST    = 3'd0;
  localparam logic [2:0] POS_HUM_HI   = 3'd2;
  localparam logic [2:0] POS_HUM_LO   = 3'd3;
  localparam logic [2:0] POS_TEMP_HI  = 3'd4;
  localparam logic [2:0] POS_TEMP_LO  = 3'd5;
  localparam logic [2:0] POS_CRC_LOW  = 3'd6;
  localparam logic [2:0] POS_LAST     = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } sfcd_in_t;

  typedef struct packed {
    logic               crc_ok;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
  } sfcd_out_t;

endpackage

// ===== hw/rtl/sfcd_crc16_byte.sv =====
module sfcd_crc16_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);
  import sfcd_pkg::*;

  // reflected crc, one byte, eight bit steps
  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// ===== hw/rtl/sfcd_frame.sv =====
module sfcd_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  sfcd_pkg::sfcd_in_t item_i,
  output logic               last_o,
  output sfcd_pkg::sfcd_out_t result_o
);
  import sfcd_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [2:0]  pos_q, pos_d;
  logic [31:0] payload_q, payload_d;
  logic [7:0]  crc_low_q, crc_low_d;

  logic [2:0]  pos;
  logic [15:0] crc_base;
  logic [15:0] crc_fed;
  logic [15:0] crc_now;
  logic [15:0] received;
  logic        ok;
  logic [15:0] mag;
  logic [15:0] temp;

  assign pos      = item_i.frame_start ? POS_FIRST : pos_q;
  assign crc_base = item_i.frame_start ? CRC_INIT : crc_q;

  sfcd_crc16_byte u_crc (
    .crc_i  (crc_base),
    .byte_i (item_i.data_byte),
    .crc_o  (crc_fed)
  );

  assign crc_now = ({1'b0, pos} < CRC_SPAN_BYTES) ? crc_fed : crc_base;
  assign last_o  = (pos == POS_LAST);

  always_comb begin
    payload_d = payload_q;
    case (pos)
      POS_HUM_HI:  payload_d[31:24] = item_i.data_byte;
      POS_HUM_LO:  payload_d[23:16] = item_i.data_byte;
      POS_TEMP_HI: payload_d[15:8]  = item_i.data_byte;
      POS_TEMP_LO: payload_d[7:0]   = item_i.data_byte;
      default:     payload_d = payload_q;
    endcase
  end

  assign crc_low_d = (pos == POS_CRC_LOW) ? item_i.data_byte : crc_low_q;

  always_comb begin
    if (last_o) begin
      pos_d = POS_FIRST;
      crc_d = CRC_INIT;
    end else begin
      pos_d = pos + 3'd1;
      crc_d = crc_now;
    end
  end

  // sign-magnitude to two's complement
  assign received = {item_i.data_byte, crc_low_q};
  assign ok       = (received == crc_now);
  assign mag      = {1'b0, payload_q[14:0]};
  assign temp     = payload_q[15] ? (16'd0 - mag) : mag;

  always_comb begin
    result_o.crc_ok             = ok;
    result_o.humidity_tenths    = ok ? payload_q[31:16] : 16'd0;
    result_o.temperature_tenths = ok ? $signed(temp) : 16'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CRC_INIT;
      pos_q     <= POS_FIRST;
      payload_q <= 32'd0;
      crc_low_q <= 8'd0;
    end else if (advance_i) begin
      crc_q     <= crc_d;
      pos_q     <= pos_d;
      payload_q <= payload_d;
      crc_low_q <= crc_low_d;
    end
  end

endmodule

// ===== hw/rtl/sensor_frame_crc_check_decode_unit.sv =====
// a result is captured in the result register when the last frame byte leaves the input register
// throughput: one byte per cycle; a stalled result holds only the bytes that end a frame
// the input register and the result register each hold one item
// reset: asynchronous, active low; frame position 0 and crc 0xffff, no result pending
`include "sensor_frame_crc_check_decode_unit_assert.svh"

module sensor_frame_crc_check_decode_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfcd_pkg::sfcd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfcd_pkg::sfcd_out_t out_data_o
);
  import sfcd_pkg::*;

  logic      s1_valid_q, s1_valid_d;
  sfcd_in_t  s1_q;
  logic      out_valid_q, out_valid_d;
  sfcd_out_t out_q;

  logic      out_free;
  logic      s1_move;
  logic      in_xfer;
  logic      last;
  sfcd_out_t result;
  logic      result_zero;

  sfcd_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_move),
    .item_i    (s1_q),
    .last_o    (last),
    .result_o  (result)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && (!last || out_free);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_xfer ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
  assign out_valid_d = (s1_move && last) ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
    if (s1_move && last) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign result_zero = (out_data_o.humidity_tenths == 16'd0) &&
                       (out_data_o.temperature_tenths == 16'sd0);

  `SFCD_ASSERT(a_stall_needs_item, in_stall_o |-> s1_valid_q)
  `SFCD_ASSERT(a_stall_only_on_last, in_stall_o |-> (last && out_valid_q && out_stall_i))
  `SFCD_ASSERT(a_held_item_stays, (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(s1_q)))
  `SFCD_ASSERT(a_bad_crc_zero, (out_valid_o && !out_data_o.crc_ok) |-> result_zero)
  `SFCD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (!out_valid_o && !in_stall_o))

endmodule
